// ----- rtl/image_convolution_filter_assert.svh -----
// assertion macros used by the checker module
`ifndef IMAGE_CONVOLUTION_FILTER_ASSERT_SVH
`define IMAGE_CONVOLUTION_FILTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ICF_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("image_convolution_filter assertion failed");

// next-cycle implication, checked outside reset
`define ICF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("image_convolution_filter assertion failed");

// next-cycle implication, also checked through reset
`define ICF_ASSERT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("image_convolution_filter reset assertion failed");

`endif

// ----- rtl/icf_pkg.sv -----
// ----------------------------------------------------------------------------
// icf_pkg
// Shared constants, register codes and types of the image convolution filter.
// ----------------------------------------------------------------------------
package icf_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int LineRows  = 4;
  localparam int LineDepth = MaxWidth;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int WidthW    = $clog2(MaxWidth) + 1;
  localparam int HeightW   = $clog2(MaxHeight) + 1;
  localparam int RowW      = HeightW + 1;
  localparam int PosW      = RowW + WidthW + 1;
  localparam int SlotW     = $clog2(LineRows);
  localparam int Taps      = 5;
  localparam int TapW      = 3;

  // floor(x/9) as (x * BoxRecip) >> 16, exact for box sums up to 9*255
  localparam logic [12:0] BoxRecip = 13'd7282;

  localparam logic [2:0] KernelBox     = 3'd0;
  localparam logic [2:0] KernelGauss   = 3'd1;
  localparam logic [2:0] KernelOutline = 3'd2;
  localparam logic [2:0] KernelEmboss  = 3'd3;
  localparam logic [2:0] KernelSharpen = 3'd4;

  localparam logic [1:0] CfgKernel = 2'd0;
  localparam logic [1:0] CfgWidth  = 2'd1;
  localparam logic [1:0] CfgHeight = 2'd2;

  localparam logic [11:0] WidthReset  = 12'd640;
  localparam logic [12:0] HeightReset = 13'd480;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [Taps-1:0]            use_pix;
    logic [Taps-1:0][SlotW-1:0] slot;
  } col_sel_t;

  typedef struct packed {
    logic                      emit;
    logic                      frame_end;
    logic [2:0]                ksel;
    logic [Taps-1:0][TapW-1:0] hsel;
  } meta_t;

endpackage

// ----- rtl/icf_in_if.sv -----
// ----------------------------------------------------------------------------
// icf_in_if
// Input pixel channel: valid/ready handshake with one raster pixel or flush.
// ----------------------------------------------------------------------------
interface icf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       flush;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, flush, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, flush, output ready);
endinterface

// ----- rtl/icf_out_if.sv -----
// ----------------------------------------------------------------------------
// icf_out_if
// Result channel: valid/ready handshake with one filtered pixel.
// ----------------------------------------------------------------------------
interface icf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

// ----- rtl/image_convolution_filter.sv -----
// ----------------------------------------------------------------------------
// image_convolution_filter
// Streaming RGB 3x3/5x5 convolution with edge clamping and selectable kernel.
// ----------------------------------------------------------------------------
// Takes one raster pixel (or flush) per clock and sustains one transaction
// per clock while the result side keeps up. Each result leaves 2*W+2
// positions after its own input pixel, plus the pipeline stages of line
// memory read, window shift, lane partial sums and scaling into the output
// buffer. After the last pixel of a frame send 2*W+2 flush transactions to
// drain it; a flush while the frame still expects pixels is dropped. Three
// channel lanes run side by side and the two-entry output buffer lets input
// continue for a while when the result side stalls. The user must write
// kernel and frame size only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
module image_convolution_filter (
  input  logic        clk,
  input  logic        rst_n,
  icf_in_if.sink      in_ch,
  icf_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  logic [2:0]  kernel_select_r;
  logic [11:0] image_width_r;
  logic [12:0] image_height_r;
  logic [icf_pkg::WidthW-1:0]  w_eff;
  logic [icf_pkg::HeightW-1:0] h_eff;

  logic acc, adv, drop, is_pix, keep, full;
  logic [icf_pkg::ColW-1:0]  col;
  logic [icf_pkg::SlotW-1:0] wr_slot;
  icf_pkg::col_sel_t csel, p1_csel_r;
  icf_pkg::meta_t    meta, p1_meta_r, p2_meta_r;
  icf_pkg::pix_t     pix, p1_pix_r;
  icf_pkg::pix_t [icf_pkg::LineRows-1:0] rd_data;
  icf_pkg::pix_t     colv [5];
  icf_pkg::pix_t     win_r [5][5];
  logic p1_valid_r, p2_valid_r, p3_valid_r, p3_emit_r, p3_fe_r;
  logic [24:0][7:0] nb_red, nb_green, nb_blue;
  logic [7:0] res_red, res_green, res_blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_select_r <= icf_pkg::KernelBox;
      image_width_r   <= icf_pkg::WidthReset;
      image_height_r  <= icf_pkg::HeightReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        icf_pkg::CfgKernel: kernel_select_r <= cfg_wdata[2:0];
        icf_pkg::CfgWidth:  image_width_r   <= cfg_wdata[11:0];
        icf_pkg::CfgHeight: image_height_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width_r == '0) w_eff = icf_pkg::WidthW'(1);
    else if (image_width_r > 12'(icf_pkg::MaxWidth)) w_eff = icf_pkg::WidthW'(icf_pkg::MaxWidth);
    else w_eff = image_width_r;
    if (image_height_r == '0) h_eff = icf_pkg::HeightW'(1);
    else if (image_height_r > 13'(icf_pkg::MaxHeight))
      h_eff = icf_pkg::HeightW'(icf_pkg::MaxHeight);
    else h_eff = image_height_r;
  end

  // pipeline moves in lockstep unless the last stage cannot unload
  assign adv         = !(p3_valid_r && p3_emit_r && full);
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && in_ch.ready;
  assign keep        = acc && !drop;
  assign pix         = '{red: in_ch.pixel_red, green: in_ch.pixel_green,
                         blue: in_ch.pixel_blue};

  icf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .flush   (in_ch.flush),
    .w       (w_eff),
    .h       (h_eff),
    .ksel    (kernel_select_r),
    .drop    (drop),
    .is_pix  (is_pix),
    .col     (col),
    .wr_slot (wr_slot),
    .csel    (csel),
    .meta    (meta)
  );

  icf_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (keep),
    .addr    (col),
    .wr_en   (keep && is_pix),
    .wr_slot (wr_slot),
    .wr_data (pix),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_pix_r  <= pix;
      p1_csel_r <= csel;
      p1_meta_r <= meta;
      p2_meta_r <= p1_meta_r;
      p3_emit_r <= p2_meta_r.emit;
      p3_fe_r   <= p2_meta_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r <= keep;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
    end
  end

  always_comb begin
    for (int t = 0; t < 5; t++) begin
      colv[t] = p1_csel_r.use_pix[t] ? p1_pix_r : rd_data[p1_csel_r.slot[t]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < 5; t++) begin
        for (int s = 0; s < 5; s++) begin
          win_r[t][s] <= '0;
        end
      end
    end else if (adv && p1_valid_r) begin
      for (int t = 0; t < 5; t++) begin
        for (int s = 0; s < 4; s++) begin
          win_r[t][s] <= win_r[t][s+1];
        end
        win_r[t][4] <= colv[t];
      end
    end
  end

  // neighbourhood with the edge clamp applied, split per channel
  always_comb begin
    for (int t = 0; t < 5; t++) begin
      for (int s = 0; s < 5; s++) begin
        nb_red[t*5+s]   = win_r[t][p2_meta_r.hsel[s]].red;
        nb_green[t*5+s] = win_r[t][p2_meta_r.hsel[s]].green;
        nb_blue[t*5+s]  = win_r[t][p2_meta_r.hsel[s]].blue;
      end
    end
  end

  icf_lane u_lane_red (
    .clk (clk), .adv (adv), .ksel (p2_meta_r.ksel), .nb (nb_red), .res (res_red)
  );

  icf_lane u_lane_green (
    .clk (clk), .adv (adv), .ksel (p2_meta_r.ksel), .nb (nb_green), .res (res_green)
  );

  icf_lane u_lane_blue (
    .clk (clk), .adv (adv), .ksel (p2_meta_r.ksel), .nb (nb_blue), .res (res_blue)
  );

  icf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && p3_valid_r && p3_emit_r),
    .red       (res_red),
    .green     (res_green),
    .blue      (res_blue),
    .frame_end (p3_fe_r),
    .full      (full),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/icf_ctrl.sv -----
// ----------------------------------------------------------------------------
// icf_ctrl
// Frame position counters; decides per transaction the line reads, the
// window column sources, horizontal edge clamp and whether a pixel is emitted.
// ----------------------------------------------------------------------------
module icf_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              acc,
  input  logic                              flush,
  input  logic [icf_pkg::WidthW-1:0]        w,
  input  logic [icf_pkg::HeightW-1:0]       h,
  input  logic [2:0]                        ksel,
  output logic                              drop,
  output logic                              is_pix,
  output logic [icf_pkg::ColW-1:0]          col,
  output logic [icf_pkg::SlotW-1:0]         wr_slot,
  output icf_pkg::col_sel_t                 csel,
  output icf_pkg::meta_t                    meta
);

  logic [icf_pkg::ColW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [icf_pkg::RowW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [icf_pkg::PosW-1:0] pos_r, pos_nxt, thr;
  logic [icf_pkg::WidthW-1:0] in_col_inc, out_col_inc;
  logic [icf_pkg::RowW-1:0] h_ext;

  assign h_ext   = {1'b0, h};
  assign is_pix  = in_row_r < h_ext;
  assign drop    = is_pix && flush;
  assign col     = in_col_r;
  assign wr_slot = in_row_r[icf_pkg::SlotW-1:0];
  assign thr     = icf_pkg::PosW'({w, 1'b0}) + icf_pkg::PosW'(2);

  always_comb begin
    int kv;
    int d;
    int c;
    int oc;
    // vertical clamp of the five rows feeding the new window column
    for (int t = 0; t < icf_pkg::Taps; t++) begin
      kv = int'(in_row_r) - 4 + t;
      if (kv < 0) kv = 0;
      if (kv > int'(h) - 1) kv = int'(h) - 1;
      csel.use_pix[t] = is_pix && (kv == int'(in_row_r));
      csel.slot[t]    = icf_pkg::SlotW'(kv);
    end
    // horizontal clamp at the row edges
    oc = int'(out_col_r);
    for (int s = 0; s < icf_pkg::Taps; s++) begin
      d = s - 2;
      c = oc + d;
      if (c < 0) d = -oc;
      else if (c > int'(w) - 1) d = int'(w) - 1 - oc;
      if (d < -2) d = -2;
      if (d > 2) d = 2;
      meta.hsel[s] = icf_pkg::TapW'(d + 2);
    end
    meta.emit = pos_r >= thr;
    meta.ksel = ksel;

    in_col_inc = {1'b0, in_col_r} + icf_pkg::WidthW'(1);
    if (in_col_inc >= w) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + 1'b1;
    end else begin
      in_col_nxt = in_col_inc[icf_pkg::ColW-1:0];
      in_row_nxt = in_row_r;
    end
    pos_nxt        = pos_r + 1'b1;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    meta.frame_end = 1'b0;
    if (meta.emit) begin
      out_col_inc = {1'b0, out_col_r} + icf_pkg::WidthW'(1);
      if (out_col_inc >= w) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_inc[icf_pkg::ColW-1:0];
      end
      // last output of the frame: everything starts over
      if (out_row_nxt >= h_ext) begin
        meta.frame_end = 1'b1;
        in_col_nxt     = '0;
        in_row_nxt     = '0;
        out_col_nxt    = '0;
        out_row_nxt    = '0;
        pos_nxt        = '0;
      end
    end else begin
      out_col_inc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pos_r     <= '0;
    end else if (acc && !drop) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule

// ----- rtl/icf_line_buf.sv -----
// ----------------------------------------------------------------------------
// icf_line_buf
// Four line memories, one per row slot, all read at the same column.
// ----------------------------------------------------------------------------
module icf_line_buf (
  input  logic                                    clk,
  input  logic                                    rd_en,
  input  logic [icf_pkg::ColW-1:0]                addr,
  input  logic                                    wr_en,
  input  logic [icf_pkg::SlotW-1:0]               wr_slot,
  input  icf_pkg::pix_t                           wr_data,
  output icf_pkg::pix_t [icf_pkg::LineRows-1:0]   rd_data
);

  for (genvar b = 0; b < icf_pkg::LineRows; b++) begin : g_bank
    icf_pkg::pix_t mem [icf_pkg::LineDepth];

    // read-first: a slot rewritten in the same cycle returns its old row
    always_ff @(posedge clk) begin
      if (rd_en) begin
        rd_data[b] <= mem[addr];
      end
      if (wr_en && (wr_slot == icf_pkg::SlotW'(b))) begin
        mem[addr] <= wr_data;
      end
    end
  end

endmodule

// ----- rtl/icf_lane.sv -----
// ----------------------------------------------------------------------------
// icf_lane
// One colour channel of the filter: partial sums, then scaling and clamping.
// ----------------------------------------------------------------------------
module icf_lane (
  input  logic             clk,
  input  logic             adv,
  input  logic [2:0]       ksel,
  input  logic [24:0][7:0] nb,
  output logic [7:0]       res
);

  logic [4:0][11:0] g_nxt, g_r;
  logic [11:0]      box;
  logic signed [12:0] sm_nxt, sm_r;
  logic [7:0]       c_r;
  logic [2:0]       ks_r;
  logic [15:0]      gsum;
  logic [24:0]      prod;

  always_comb begin
    for (int t = 0; t < 5; t++) begin
      g_nxt[t] = 12'(nb[t*5]) + (12'(nb[t*5+1]) << 2) + 12'(nb[t*5+2]) * 12'd6
               + (12'(nb[t*5+3]) << 2) + 12'(nb[t*5+4]);
    end
    box = 12'(nb[6]) + 12'(nb[7]) + 12'(nb[8]) + 12'(nb[11]) + 12'(nb[12])
        + 12'(nb[13]) + 12'(nb[16]) + 12'(nb[17]) + 12'(nb[18]);
    case (ksel)
      icf_pkg::KernelOutline:
        sm_nxt = $signed(13'(nb[12]) * 13'd9) - $signed({1'b0, box});
      icf_pkg::KernelEmboss:
        sm_nxt = $signed(13'(nb[12])) + $signed(13'(nb[13])) + $signed(13'(nb[17]))
               + $signed(13'(nb[18]) << 1) - $signed(13'(nb[6]) << 1)
               - $signed(13'(nb[7])) - $signed(13'(nb[11]));
      icf_pkg::KernelSharpen:
        sm_nxt = $signed(13'(nb[12]) * 13'd5) - $signed(13'(nb[7])) - $signed(13'(nb[11]))
               - $signed(13'(nb[13])) - $signed(13'(nb[17]));
      default:
        sm_nxt = $signed({1'b0, box});
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r  <= g_nxt;
      sm_r <= sm_nxt;
      c_r  <= nb[12];
      ks_r <= ksel;
    end
  end

  assign gsum = 16'(g_r[0]) + (16'(g_r[1]) << 2) + 16'(g_r[2]) * 16'd6
              + (16'(g_r[3]) << 2) + 16'(g_r[4]);
  assign prod = 25'(sm_r[11:0]) * 25'(icf_pkg::BoxRecip);

  always_comb begin
    case (ks_r) inside
      icf_pkg::KernelBox:   res = prod[23:16];
      icf_pkg::KernelGauss: res = gsum[15:8];
      icf_pkg::KernelOutline, icf_pkg::KernelEmboss, icf_pkg::KernelSharpen: begin
        if (sm_r < 0) res = 8'd0;
        else if (sm_r > 13'sd255) res = 8'd255;
        else res = sm_r[7:0];
      end
      default:              res = c_r;
    endcase
  end

endmodule

// ----- rtl/icf_out_buf.sv -----
// ----------------------------------------------------------------------------
// icf_out_buf
// Merges the three lane results into one pixel and holds it in a two-entry
// buffer that decouples the result channel from the filter pipeline.
// ----------------------------------------------------------------------------
module icf_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic              frame_end,
  output logic              full,
  icf_out_if.source         out_ch
);

  icf_pkg::pix_t pix_r [2];
  logic [1:0]    fe_r;
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          pop;

  assign full             = cnt_r == 2'd2;
  assign out_ch.valid     = cnt_r != 2'd0;
  assign pop              = out_ch.valid && out_ch.ready;
  assign out_ch.out_red   = pix_r[rd_ptr_r].red;
  assign out_ch.out_green = pix_r[rd_ptr_r].green;
  assign out_ch.out_blue  = pix_r[rd_ptr_r].blue;
  assign out_ch.frame_end = fe_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      pix_r[wr_ptr_r] <= '{red: red, green: green, blue: blue};
      fe_r[wr_ptr_r]  <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/icf_checker.sv -----
// ----------------------------------------------------------------------------
// icf_checker
// Port-level checks of the image convolution filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "image_convolution_filter_assert.svh"

module icf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_frame_end
);

  // input only stalls when a result is waiting
  `ICF_ASSERT_NOW(a_stall_has_result, !in_ready, out_valid)
  `ICF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ICF_ASSERT_NEXT(a_fe_hold, out_valid && !out_ready, $stable(out_frame_end))
  `ICF_ASSERT_RST(a_rst_clear, !rst_n, !out_valid)

endmodule

bind image_convolution_filter icf_checker u_icf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_frame_end (out_ch.frame_end)
);

// ----- dv/image_convolution_filter_tb.sv -----
// ----------------------------------------------------------------------------
// image_convolution_filter_tb
// Streams whole RGB frames through the filter, each drained with flush
// transactions, under every kernel code and a range of frame sizes. Results
// are checked against a bit-exact line buffer and window model. The checks
// cover early flushes, late pixels, random stalls on both channels and one
// long hold on the result side.
// ----------------------------------------------------------------------------
module image_convolution_filter_tb;

  localparam int CycleLimit = 1000000;
  localparam int DrainWait  = 8;
  localparam int LongHold   = 300;

  typedef struct packed {
    icf_pkg::pix_t px;
    logic          frame_end;
  } filt_res_t;

  class pixel_scoreboard;
    logic [2:0]  ksel;
    logic [11:0] wreg;
    logic [12:0] hreg;
    logic [23:0] lines [0:icf_pkg::LineRows*icf_pkg::MaxWidth-1];
    logic [23:0] win [0:24];
    int unsigned icol, irow, ocol, orow;
    filt_res_t   owed_q[$];
    int          errors;

    function new();
      ksel = icf_pkg::KernelBox;
      wreg = icf_pkg::WidthReset;
      hreg = icf_pkg::HeightReset;
      foreach (lines[i]) lines[i] = '0;
      foreach (win[i]) win[i] = '0;
      icol = 0; irow = 0; ocol = 0; orow = 0;
      errors = 0;
    endfunction

    function void configure(logic [1:0] idx, logic [12:0] v);
      case (idx)
        icf_pkg::CfgKernel: ksel = v[2:0];
        icf_pkg::CfgWidth:  wreg = v[11:0];
        icf_pkg::CfgHeight: hreg = v;
        default: ;
      endcase
    endfunction

    function int unsigned cur_w();
      if (wreg == 0) return 1;
      if (wreg > icf_pkg::MaxWidth) return icf_pkg::MaxWidth;
      return wreg;
    endfunction

    function int unsigned cur_h();
      if (hreg == 0) return 1;
      if (hreg > icf_pkg::MaxHeight) return icf_pkg::MaxHeight;
      return hreg;
    endfunction

    function logic [7:0] clamp_lane(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    function logic [7:0] filter_lane(logic [23:0] nb [25], int sh);
      int acc;
      int g [5];
      int kw [9];
      acc = 0;
      g = '{1, 4, 6, 4, 1};
      if (ksel == icf_pkg::KernelGauss) begin
        for (int t = 0; t < 5; t++)
          for (int s = 0; s < 5; s++)
            acc += g[t] * g[s] * int'(nb[t*5+s][sh +: 8]);
        return clamp_lane(acc / 256);
      end
      case (ksel)
        icf_pkg::KernelBox:     kw = '{1, 1, 1, 1, 1, 1, 1, 1, 1};
        icf_pkg::KernelOutline: kw = '{-1, -1, -1, -1, 8, -1, -1, -1, -1};
        icf_pkg::KernelEmboss:  kw = '{-2, -1, 0, -1, 1, 1, 0, 1, 2};
        icf_pkg::KernelSharpen: kw = '{0, -1, 0, -1, 5, -1, 0, -1, 0};
        default:                return nb[12][sh +: 8];
      endcase
      for (int t = 0; t < 3; t++)
        for (int s = 0; s < 3; s++)
          acc += kw[t*3+s] * int'(nb[(t+1)*5+s+1][sh +: 8]);
      if (ksel == icf_pkg::KernelBox) return clamp_lane(acc / 9);
      return clamp_lane(acc);
    endfunction

    // one pipeline step of the filter for an accepted input transaction
    function void note_input(icf_pkg::pix_t px, logic fl);
      longint w, h, k, d, c, pos;
      bit live;
      int unsigned col;
      logic [23:0] v;
      logic [23:0] nb [25];
      filt_res_t r;
      w = cur_w();
      h = cur_h();
      live = irow < h;
      col = icol % icf_pkg::MaxWidth;
      pos = longint'(irow) * w + icol;
      if (live && fl) return;
      for (int t = 0; t < 5; t++) begin
        k = longint'(irow) - 4 + t;
        if (k < 0) k = 0;
        if (k > h - 1) k = h - 1;
        if (live && k == irow) v = px;
        else v = lines[(k & 3) * icf_pkg::MaxWidth + col];
        for (int s = 0; s < 4; s++) win[t*5+s] = win[t*5+s+1];
        win[t*5+4] = v;
      end
      if (live) lines[(irow & 3) * icf_pkg::MaxWidth + col] = px;
      icol++;
      if (icol >= w) begin
        icol = 0;
        irow++;
      end
      if (pos < 2*w + 2) return;
      // columns beyond the row edge take the edge column
      for (int s = 0; s < 5; s++) begin
        d = s - 2;
        c = longint'(ocol) + d;
        if (c < 0) d = -longint'(ocol);
        else if (c > w - 1) d = w - 1 - ocol;
        if (d < -2) d = -2;
        if (d > 2) d = 2;
        for (int t = 0; t < 5; t++) nb[t*5+s] = win[t*5+int'(d)+2];
      end
      r.px.red   = filter_lane(nb, 16);
      r.px.green = filter_lane(nb, 8);
      r.px.blue  = filter_lane(nb, 0);
      r.frame_end = 1'b0;
      ocol++;
      if (ocol >= w) begin
        ocol = 0;
        orow++;
      end
      if (orow >= h) begin
        r.frame_end = 1'b1;
        icol = 0; irow = 0; ocol = 0; orow = 0;
      end
      owed_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(filt_res_t got);
      filt_res_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected pixel %h fe=%0b", got.px, got.frame_end));
        return;
      end
      want = owed_q.pop_front();
      if (got.px.red !== want.px.red)
        report($sformatf("red %h, expected %h", got.px.red, want.px.red));
      if (got.px.green !== want.px.green)
        report($sformatf("green %h, expected %h", got.px.green, want.px.green));
      if (got.px.blue !== want.px.blue)
        report($sformatf("blue %h, expected %h", got.px.blue, want.px.blue));
      if (got.frame_end !== want.frame_end)
        report($sformatf("frame_end %b, expected %b", got.frame_end, want.frame_end));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_wdata;

  icf_in_if  in_ch();
  icf_out_if out_ch();

  image_convolution_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pixel_scoreboard sb = new();
  int cycles;
  bit calm;
  int hold_asked;
  int hold_served;
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("** image_convolution_filter: FAILED **");
      $finish;
    end else if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.out_red, out_ch.out_green, out_ch.out_blue,
                       out_ch.frame_end});
    end
  end

  // result side: random stall bursts, plus the long hold when asked for
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_asked != hold_served) begin
        hold_served++;
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task send_item(icf_pkg::pix_t px, logic fl);
    in_ch.valid       <= 1'b1;
    in_ch.pixel_red   <= px.red;
    in_ch.pixel_green <= px.green;
    in_ch.pixel_blue  <= px.blue;
    in_ch.flush       <= fl;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(px, fl);
    items_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task write_reg(logic [1:0] idx, logic [12:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.configure(idx, v);
  endtask

  task wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // one complete frame; noise adds early flushes and late pixels
  task run_frame(logic [2:0] k, logic [11:0] wr, logic [12:0] hr, bit extremes,
                 int noise_pct, int hold_at, int pause_at);
    int unsigned w, h;
    icf_pkg::pix_t px;
    write_reg(icf_pkg::CfgKernel, {10'($urandom), k});
    write_reg(icf_pkg::CfgWidth, {1'b0, wr});
    write_reg(icf_pkg::CfgHeight, hr);
    cfg_we <= 1'b0;
    @(posedge clk);
    w = sb.cur_w();
    h = sb.cur_h();
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(1, 100) <= noise_pct)
        send_item(icf_pkg::pix_t'($urandom), 1'b1);
      if (i == hold_at) hold_asked++;
      if (i == pause_at) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.owed_q.size() != 0);
      end
      px = icf_pkg::pix_t'($urandom);
      if (extremes) begin
        px.red   = ((i + i / w) % 2) ? 8'hff : 8'h00;
        px.green = ($urandom_range(0, 1)) ? 8'hff : 8'h00;
        px.blue  = ((i + i / w) % 2) ? 8'h00 : 8'hff;
      end
      send_item(px, 1'b0);
    end
    for (int i = 0; i < 2 * w + 2; i++)
      send_item(icf_pkg::pix_t'($urandom), !($urandom_range(1, 100) <= noise_pct));
    wait_drained();
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = icf_pkg::CfgKernel;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.pixel_red   = '0;
    in_ch.pixel_green = '0;
    in_ch.pixel_blue  = '0;
    in_ch.flush       = 1'b0;
    cycles            = 0;
    calm              = 1'b0;
    hold_asked        = 0;
    hold_served       = 0;
    items_sent        = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every kernel on saturated patterns, unused codes on single pixels
    for (int k = icf_pkg::KernelBox; k <= icf_pkg::KernelSharpen; k++)
      run_frame(3'(k), 12'd3, 13'd2, 1'b1, 20, -1, -1);
    for (int k = 5; k < 8; k++)
      run_frame(3'(k), 12'd1, 13'd1, 1'b1, 30, -1, -1);

    // zero size registers act as a single pixel
    run_frame(icf_pkg::KernelGauss, 12'd0, 13'd0, 1'b0, 0, -1, -1);

    // back-pressure: long result hold, then a sender pause mid-frame
    run_frame(icf_pkg::KernelGauss, 12'd64, 13'd6, 1'b0, 0, 160, 300);

    while (items_sent < 1450) begin
      if (items_sent > 1200) calm = 1'b1;
      run_frame(($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4)) : 3'($urandom),
                12'($urandom_range(1, 12)), 13'($urandom_range(1, 8)),
                $urandom_range(0, 7) == 0, ($urandom_range(0, 3) == 0) ? 8 : 0,
                -1, -1);
    end

    wait_drained();
    if (sb.errors == 0) $display("** image_convolution_filter: PASSED **");
    else $display("** image_convolution_filter: FAILED **");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/icf_pkg.sv
rtl/icf_in_if.sv
rtl/icf_out_if.sv
rtl/icf_ctrl.sv
rtl/icf_line_buf.sv
rtl/icf_lane.sv
rtl/icf_out_buf.sv
rtl/image_convolution_filter.sv
rtl/icf_checker.sv
dv/image_convolution_filter_tb.sv
